### rtl/smd_pkg.sv
// Shared constants for the stuck-motion detector: register map, widths and reset values.
`default_nettype none

package smd_pkg;

   // Widths of the configuration registers and result fields.
   localparam int unsigned THRESH_W   = 15;
   localparam int unsigned LIMIT_W    = 4;
   localparam int unsigned DECAY_W    = 8;
   localparam int unsigned STUCK_W    = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 15;

   // Register map of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINEAR_THRESHOLD  = 3'd0,
      CSR_ANGULAR_THRESHOLD = 3'd1,
      CSR_PROGRESS_LIMIT    = 3'd2,
      CSR_SLOW_DECAY        = 3'd3,
      CSR_FAST_DECAY        = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [THRESH_W-1:0] LINEAR_THRESHOLD_RST  = 15'd410;
   localparam logic [THRESH_W-1:0] ANGULAR_THRESHOLD_RST = 15'd819;
   localparam logic [LIMIT_W-1:0]  PROGRESS_LIMIT_RST    = 4'd10;
   localparam logic [DECAY_W-1:0]  SLOW_DECAY_RST        = 8'd230;
   localparam logic [DECAY_W-1:0]  FAST_DECAY_RST        = 8'd128;

   // Item kinds on the input channel.
   localparam logic REQ_SAMPLE  = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   localparam logic [STUCK_W-1:0] STUCK_MAX = {STUCK_W{1'b1}};

endpackage

`default_nettype wire

### rtl/stuck_motion_detector.sv
// Stuck-motion detector: velocity averaging and stuck/progress counting.
//
// Usage. Each word on the req_ channel is either a velocity sample
// (req_type low) carrying a signed Q4.12 linear and angular velocity, or
// a restart (req_type high) that clears both counts. Every accepted word
// produces exactly one word on the rsp_ channel holding the stuck count,
// the progress count and the not-moving flag after that word.
// rsp_valid rises once the result register loads: the word sits in the
// input register while the averages, compares and counters are worked
// out, and the result register loads when it is free or being drained.
// Throughput is one word per cycle while the receiver keeps rsp_ready
// high; the averaging multipliers and the counter update all fit
// between the input and result registers.
// When the receiver stalls, the result register holds, the input register
// fills, and req_ready falls only once both are occupied; a word is
// taken again in the same cycle in which the result is taken.
// The csr_ port writes the five configuration registers; it is always
// ready and is only meant to be written while no word is in flight.
// Reset is synchronous; it empties both registers, clears the averages
// and counts, and loads the default thresholds, limit and decay factors.
`default_nettype none

module stuck_motion_detector #(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,

   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_type,
   input  wire signed [SAMPLE_BITS-1:0]         req_linear_velocity,
   input  wire signed [SAMPLE_BITS-1:0]         req_angular_velocity,

   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [smd_pkg::STUCK_W-1:0]          rsp_stuck_count,
   output logic [smd_pkg::LIMIT_W-1:0]          rsp_progress_count,
   output logic                                 rsp_not_moving,

   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [smd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [smd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // Averages carry eight more fraction bits than the samples.
   localparam int unsigned AW = SAMPLE_BITS + 8;
   // Difference between an average and a scaled sample.
   localparam int unsigned DW = AW + 1;
   // Difference times the nine-bit signed decay factor.
   localparam int unsigned PW = DW + 9;
   // Comparison width, wide enough for every magnitude and scaled threshold.
   localparam int unsigned CW = SAMPLE_BITS + 26;

   localparam int unsigned TW  = smd_pkg::THRESH_W;
   localparam int unsigned LW  = smd_pkg::LIMIT_W;
   localparam int unsigned DKW = smd_pkg::DECAY_W;
   localparam int unsigned SW  = smd_pkg::STUCK_W;

   // New average = sample*256 + floor(d * (avg - sample*256) / 256).
   // This equals the convex blend of the old average and the sample.
   function automatic logic signed [AW-1:0] blend(
      input logic signed [AW-1:0]          avg,
      input logic signed [SAMPLE_BITS-1:0] smp,
      input logic [DKW-1:0]                dec
   );
      logic signed [DW-1:0] s256;
      logic signed [DW-1:0] diff;
      logic signed [PW-1:0] prod;
      logic signed [DW:0]   sum;
      s256 = {smp[SAMPLE_BITS-1], smp, 8'd0};
      diff = {avg[AW-1], avg} - s256;
      prod = diff * $signed({1'b0, dec});
      sum  = {s256[DW-1], s256} + $signed(prod[PW-1:8]);
      return sum[AW-1:0];
   endfunction

   function automatic logic [CW-1:0] mag_of(input logic signed [CW-1:0] v);
      logic [CW-1:0] neg;
      neg = -v;
      return v[CW-1] ? neg : v;
   endfunction

   // Configuration registers.
   logic [TW-1:0]  lin_thresh_ff, ang_thresh_ff;
   logic [LW-1:0]  limit_ff;
   logic [DKW-1:0] slow_decay_ff, fast_decay_ff;

   // Input register.
   logic                          in_valid_ff;
   logic                          in_type_ff;
   logic signed [SAMPLE_BITS-1:0] in_lin_ff, in_ang_ff;

   // Detector state.
   logic signed [AW-1:0] slow_lin_ff, slow_ang_ff, fast_lin_ff, fast_ang_ff;
   logic signed [AW-1:0] slow_lin_in, slow_ang_in, fast_lin_in, fast_ang_in;
   logic [LW-1:0]        moving_ff, moving_in;
   logic [SW-1:0]        stuck_ff, stuck_in;

   // Result register.
   logic                 rsp_valid_ff;
   logic [SW-1:0]        rsp_stuck_ff;
   logic [LW-1:0]        rsp_progress_ff;
   logic                 rsp_not_moving_ff;
   logic                 not_moving_in;

   logic advance;
   logic csr_write;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stuck_count    = rsp_stuck_ff;
   assign rsp_progress_count = rsp_progress_ff;
   assign rsp_not_moving     = rsp_not_moving_ff;

   // Configuration writes; indexes outside the map are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_thresh_ff <= smd_pkg::LINEAR_THRESHOLD_RST;
         ang_thresh_ff <= smd_pkg::ANGULAR_THRESHOLD_RST;
         limit_ff      <= smd_pkg::PROGRESS_LIMIT_RST;
         slow_decay_ff <= smd_pkg::SLOW_DECAY_RST;
         fast_decay_ff <= smd_pkg::FAST_DECAY_RST;
      end else if (csr_write) begin
         case (csr_index)
            smd_pkg::CSR_LINEAR_THRESHOLD:  lin_thresh_ff <= csr_wdata[TW-1:0];
            smd_pkg::CSR_ANGULAR_THRESHOLD: ang_thresh_ff <= csr_wdata[TW-1:0];
            smd_pkg::CSR_PROGRESS_LIMIT:    limit_ff      <= csr_wdata[LW-1:0];
            smd_pkg::CSR_SLOW_DECAY:        slow_decay_ff <= csr_wdata[DKW-1:0];
            smd_pkg::CSR_FAST_DECAY:        fast_decay_ff <= csr_wdata[DKW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: loads whenever it is empty or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_type_ff <= req_type;
         in_lin_ff  <= req_linear_velocity;
         in_ang_ff  <= req_angular_velocity;
      end
   end

   // Update logic for the word in the input register.
   logic signed [CW-1:0] lin_x, ang_x;
   logic [CW-1:0]        lin_thr_256, ang_thr_256, lin_thr, ang_thr;
   logic [CW-1:0]        chatter_mag;
   logic signed [DW-1:0] chatter_diff;
   logic                 slow_ang_small, not_rotating, chattering;
   logic [LW:0]          moving_next;

   always_comb begin
      lin_x       = {{(CW-SAMPLE_BITS){in_lin_ff[SAMPLE_BITS-1]}}, in_lin_ff};
      ang_x       = {{(CW-SAMPLE_BITS){in_ang_ff[SAMPLE_BITS-1]}}, in_ang_ff};
      lin_thr     = {{(CW-TW){1'b0}}, lin_thresh_ff};
      ang_thr     = {{(CW-TW){1'b0}}, ang_thresh_ff};
      lin_thr_256 = {{(CW-TW-8){1'b0}}, lin_thresh_ff, 8'd0};
      ang_thr_256 = {{(CW-TW-8){1'b0}}, ang_thresh_ff, 8'd0};

      // An empty progress count restarts the averages from this sample.
      if (moving_ff == '0) begin
         slow_lin_in = {in_lin_ff, 8'd0};
         fast_lin_in = {in_lin_ff, 8'd0};
         slow_ang_in = {in_ang_ff, 8'd0};
         fast_ang_in = {in_ang_ff, 8'd0};
      end else begin
         slow_lin_in = blend(slow_lin_ff, in_lin_ff, slow_decay_ff);
         slow_ang_in = blend(slow_ang_ff, in_ang_ff, slow_decay_ff);
         fast_lin_in = blend(fast_lin_ff, in_lin_ff, fast_decay_ff);
         fast_ang_in = blend(fast_ang_ff, in_ang_ff, fast_decay_ff);
      end

      not_moving_in =
         (mag_of({{(CW-AW){slow_lin_in[AW-1]}}, slow_lin_in}) < lin_thr_256) &&
         (mag_of({{(CW-AW){fast_lin_in[AW-1]}}, fast_lin_in}) < lin_thr_256) &&
         (mag_of(lin_x) < lin_thr);

      slow_ang_small =
         mag_of({{(CW-AW){slow_ang_in[AW-1]}}, slow_ang_in}) < ang_thr_256;
      not_rotating = slow_ang_small &&
         (mag_of({{(CW-AW){fast_ang_in[AW-1]}}, fast_ang_in}) < ang_thr_256) &&
         (mag_of(ang_x) < ang_thr);
      chatter_diff = {fast_ang_in[AW-1], fast_ang_in}
                   - {in_ang_ff[SAMPLE_BITS-1], in_ang_ff, 8'd0};
      chatter_mag  = mag_of({{(CW-DW){chatter_diff[DW-1]}}, chatter_diff});
      chattering   = slow_ang_small && (chatter_mag > ang_thr_256);

      moving_next = {1'b0, moving_ff} + {{LW{1'b0}}, 1'b1};
      moving_in   = moving_ff;
      stuck_in    = stuck_ff;

      if (in_type_ff == smd_pkg::REQ_RESTART) begin
         // Restart keeps the averages and clears both counts.
         slow_lin_in   = slow_lin_ff;
         slow_ang_in   = slow_ang_ff;
         fast_lin_in   = fast_lin_ff;
         fast_ang_in   = fast_ang_ff;
         not_moving_in = 1'b0;
         moving_in     = '0;
         stuck_in      = '0;
      end else if (not_moving_in) begin
         if ((not_rotating || chattering) && stuck_ff != smd_pkg::STUCK_MAX) begin
            stuck_in = stuck_ff + {{(SW-1){1'b0}}, 1'b1};
         end
      end else if (moving_next > {1'b0, limit_ff}) begin
         // Enough progress: clamp at the limit and forget stuck evidence.
         moving_in = limit_ff;
         stuck_in  = '0;
      end else begin
         moving_in = moving_next[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_lin_ff <= '0;
         slow_ang_ff <= '0;
         fast_lin_ff <= '0;
         fast_ang_ff <= '0;
         moving_ff   <= '0;
         stuck_ff    <= '0;
      end else if (advance) begin
         slow_lin_ff <= slow_lin_in;
         slow_ang_ff <= slow_ang_in;
         fast_lin_ff <= fast_lin_in;
         fast_ang_ff <= fast_ang_in;
         moving_ff   <= moving_in;
         stuck_ff    <= stuck_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_stuck_ff      <= stuck_in;
         rsp_progress_ff   <= moving_in;
         rsp_not_moving_ff <= not_moving_in;
      end
   end

   // The input side stalls only when both registers are occupied.
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff))
      else $error("req_ready low while a register is free");

   // A restart always reports cleared counts and a moving robot.
   a_restart_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_type_ff == smd_pkg::REQ_RESTART) |=>
         (rsp_stuck_ff == '0 && rsp_progress_ff == '0 && !rsp_not_moving_ff))
      else $error("restart did not clear the counts");

   // The stuck count only steps by one, holds, or clears.
   a_stuck_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (stuck_ff == $past(stuck_ff) || stuck_ff == '0 ||
                   stuck_ff == $past(stuck_ff) + {{(SW-1){1'b0}}, 1'b1}))
      else $error("stuck count jumped");

   // A new result appears only when a word moved through the update logic.
   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without an update");

   // The progress count moves only on a word that was not stationary.
   a_progress_on_motion: assert property (@(posedge clock) disable iff (reset)
      (advance && in_type_ff == smd_pkg::REQ_SAMPLE && not_moving_in) |=>
         (moving_ff == $past(moving_ff)))
      else $error("progress count changed on a stationary sample");

endmodule

`default_nettype wire
